// File: hw/rtl/twodo_pkg.sv
package twodo_pkg;

	// signed working width for displacements and rotated terms
	localparam int TW = 56;

	// shared multiply/divide unit operand widths
	localparam int MD_A_W = 84;
	localparam int MD_B_W = 35;
	localparam int MD_CNT_W = 7;
	localparam int MUL_STEPS = 35;
	localparam int DIV_STEPS = 80;

	// cordic datapath width (q1.30 plus headroom)
	localparam int CD_W = 34;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_W = 24;

	localparam logic [CFG_W-1:0] DIAM_RST = 24'd180224;
	localparam logic [CFG_W-1:0] LEFT_RST = 24'd442368;
	localparam logic [CFG_W-1:0] RIGHT_RST = 24'd442368;
	localparam logic [CFG_W-1:0] BACK_RST = 24'd180224;

	// pi/360 in q0.32
	localparam logic [31:0] ARC_K = 32'd37480660;
	localparam logic [CD_W-1:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [9:0] DEG_SCALE = 10'd720;

	localparam logic signed [32:0] DELTA_MAX = 33'sd8388607;
	localparam logic signed [32:0] DELTA_MIN = -33'sd8388607;

	localparam logic signed [TW-1:0] S32_MAX = 56'sh0000_007F_FFFF_FF;
	localparam logic signed [TW-1:0] S32_MIN = 56'shFF_FFFF_8000_0000;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
		32'h00000000, 32'h00000000
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIAMETER = 8'd0,
		REG_LEFT_OFS = 8'd1,
		REG_RIGHT_OFS = 8'd2,
		REG_BACK_OFS = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic div;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic start;
		logic [31:0] angle;
	} cd_req_t;

	function automatic logic signed [23:0] sat_delta(input logic signed [32:0] d);
		if (d > DELTA_MAX) begin
			return DELTA_MAX[23:0];
		end else if (d < DELTA_MIN) begin
			return DELTA_MIN[23:0];
		end
		return d[23:0];
	endfunction

	function automatic logic [TW-1:0] mag(input logic signed [TW-1:0] v);
		return v[TW-1] ? TW'(-v) : TW'(v);
	endfunction

	function automatic logic signed [TW-1:0] with_sign(input logic [TW-1:0] m, input logic neg);
		return neg ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [TW-1:0] v);
		if (v > S32_MAX) begin
			return 32'h7FFF_FFFF;
		end else if (v < S32_MIN) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// File: hw/rtl/twodo_muldiv.sv
module twodo_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  twodo_pkg::md_req_t  req,
	output logic                done,
	output logic [twodo_pkg::MD_A_W-1:0] res
);

	localparam int AW = twodo_pkg::MD_A_W;
	localparam int BW = twodo_pkg::MD_B_W;
	localparam int CW = twodo_pkg::MD_CNT_W;

	logic          busy_q;
	logic          div_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] opa_q;
	logic [BW-1:0] opb_q;
	logic [BW:0]   rem_q;
	logic [BW:0]   trial;
	logic          trial_ge;

	// restoring division: dividend sits in the low 80 bits of opa
	assign trial = {rem_q[BW-1:0], opa_q[twodo_pkg::DIV_STEPS-1]};
	assign trial_ge = trial >= {1'b0, opb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
			opa_q <= '0;
			opb_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q <= req.div;
				acc_q <= '0;
				opa_q <= req.a;
				opb_q <= req.b;
				rem_q <= '0;
				cnt_q <= req.div ? CW'(twodo_pkg::DIV_STEPS) : CW'(twodo_pkg::MUL_STEPS);
			end else if (busy_q) begin
				if (!div_q) begin
					// shift-add, multiplier lsb first
					if (opb_q[0]) begin
						acc_q <= acc_q + opa_q;
					end
					opa_q <= {opa_q[AW-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[BW-1:1]};
				end else begin
					opa_q <= {opa_q[AW-2:0], 1'b0};
					if (trial_ge) begin
						rem_q <= trial - {1'b0, opb_q};
						acc_q <= {acc_q[AW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						acc_q <= {acc_q[AW-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res = acc_q;

endmodule

// File: hw/rtl/twodo_cordic.sv
module twodo_cordic #(
	parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  twodo_pkg::cd_req_t  req,
	output logic                done,
	output logic signed [twodo_pkg::CD_W-1:0] cos_val,
	output logic signed [twodo_pkg::CD_W-1:0] sin_val
);

	localparam int W = twodo_pkg::CD_W;
	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

	logic              busy_q;
	logic              done_q;
	logic              flip_q;
	logic [4:0]        step_q;
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] z_q;
	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;
	logic signed [W-1:0] atan_s;
	logic [31:0]       quarter;
	logic              flip;
	logic [31:0]       folded;

	// fold the left half plane onto the right, negate the result afterwards
	assign quarter = req.angle + 32'h4000_0000;
	assign flip = quarter[31];
	assign folded = flip ? req.angle + 32'h8000_0000 : req.angle;

	assign dx = x_q >>> step_q;
	assign dy = y_q >>> step_q;
	assign atan_s = signed'(W'(twodo_pkg::ATAN_TAB[step_q]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			flip_q <= 1'b0;
			step_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				flip_q <= flip;
				step_q <= '0;
				x_q <= signed'(twodo_pkg::CORDIC_GAIN);
				y_q <= '0;
				z_q <= W'(signed'(folded));
			end else if (busy_q) begin
				if (!z_q[W-1]) begin
					x_q <= x_q - dy;
					y_q <= y_q + dx;
					z_q <= z_q - atan_s;
				end else begin
					x_q <= x_q + dy;
					y_q <= y_q - dx;
					z_q <= z_q + atan_s;
				end
				step_q <= step_q + 5'd1;
				if (step_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

// File: hw/rtl/tracking_wheel_odometry_top.sv
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: mode; tdata: left, right, back counts
// m_*      out  m_tvalid/m_tready  tdata: pos_x, pos_y, heading
// cfg_*    in   cfg_valid/cfg_ready cfg_index register index, cfg_data 24-bit value
//
// one item at a time; multiplies and divides run on the shared shift-add/restoring
// unit, rotations on the cordic unit. a turning sample: 9 multiplies, 3 divides,
// 2 rotations.
// reset restores the register defaults and zeroes pose and previous counts.
// a finished result waits in the output register while the next item is accepted.
module tracking_wheel_odometry_top #(
	parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // left_count, right_count, back_count
	input  logic [0:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // pos_x, pos_y, heading
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [twodo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twodo_pkg::CFG_W-1:0]     cfg_data
);

	localparam int TW = twodo_pkg::TW;
	localparam int AW = twodo_pkg::MD_A_W;
	localparam int BW = twodo_pkg::MD_B_W;
	localparam int CDW = twodo_pkg::CD_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_N_W, ST_Q_W, ST_PB_W, ST_QB_W, ST_PR_W, ST_QR_W,
		ST_CH_W, ST_SX_W, ST_SY_W, ST_AB_W, ST_AB2_W, ST_AR_W, ST_AR2_W,
		ST_CM_W, ST_T1_W, ST_T2_W, ST_T3_W, ST_T4_W, ST_DONE
	} st_t;

	st_t state_q;

	logic [23:0] diam_q, left_ofs_q, right_ofs_q, back_ofs_q;

	logic [31:0] prev_l_q, prev_r_q, prev_b_q;
	logic [31:0] head_q, x_q, y_q;
	logic signed [23:0] dl_q, dr_q, db_q;
	logic signed [24:0] e_q;
	logic [24:0] w_q;
	logic [31:0] dba_q, hba_q;
	logic signed [TW-1:0] lx_q, ly_q, u_q, sx_q;
	logic signed [CDW-1:0] sh_q, c_q, s_q;
	logic m_tvalid_q;
	logic [95:0] m_tdata_q;

	twodo_pkg::md_req_t md_req_q;
	twodo_pkg::cd_req_t cd_req_q;
	logic md_done;
	logic [AW-1:0] md_res;
	logic cd_done;
	logic signed [CDW-1:0] cd_cos, cd_sin;

	logic signed [24:0] e_now;
	logic [TW-1:0] prod30;
	logic [TW-1:0] prod32;
	logic [TW-1:0] quot;
	logic signed [TW-1:0] t_now;
	logic [31:0] half_mag;

	twodo_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .req(md_req_q), .done(md_done), .res(md_res)
	);

	twodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cd (
		.clk(clk), .arst_n(arst_n), .req(cd_req_q), .done(cd_done),
		.cos_val(cd_cos), .sin_val(cd_sin)
	);

	assign e_now = 25'(dl_q) - 25'(dr_q);
	assign prod30 = {2'b00, md_res[AW-1:30]};
	assign prod32 = {4'b0000, md_res[AW-1:32]};
	assign quot = md_res[TW-1:0];
	assign half_mag = md_res[32:1];

	// signed product of a displacement and a q1.30 cos/sin, shifted right by 30 bits, for the current rotation step
	always_comb begin
		unique case (state_q)
			ST_T1_W: t_now = twodo_pkg::with_sign(prod30, lx_q[TW-1] ^ c_q[CDW-1]);
			ST_T2_W: t_now = twodo_pkg::with_sign(prod30, ly_q[TW-1] ^ s_q[CDW-1]);
			ST_T3_W: t_now = twodo_pkg::with_sign(prod30, ly_q[TW-1] ^ c_q[CDW-1]);
			ST_T4_W: t_now = twodo_pkg::with_sign(prod30, lx_q[TW-1] ^ s_q[CDW-1]);
			default: t_now = '0;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q <= twodo_pkg::DIAM_RST;
			left_ofs_q <= twodo_pkg::LEFT_RST;
			right_ofs_q <= twodo_pkg::RIGHT_RST;
			back_ofs_q <= twodo_pkg::BACK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				twodo_pkg::REG_DIAMETER:  diam_q <= cfg_data;
				twodo_pkg::REG_LEFT_OFS:  left_ofs_q <= cfg_data;
				twodo_pkg::REG_RIGHT_OFS: right_ofs_q <= cfg_data;
				twodo_pkg::REG_BACK_OFS:  back_ofs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_l_q <= '0;
			prev_r_q <= '0;
			prev_b_q <= '0;
			head_q <= '0;
			x_q <= '0;
			y_q <= '0;
			dl_q <= '0;
			dr_q <= '0;
			db_q <= '0;
			e_q <= '0;
			w_q <= '0;
			dba_q <= '0;
			hba_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			u_q <= '0;
			sx_q <= '0;
			sh_q <= '0;
			c_q <= '0;
			s_q <= '0;
			md_req_q <= '0;
			cd_req_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			md_req_q.start <= 1'b0;
			cd_req_q.start <= 1'b0;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) begin
							prev_l_q <= '0;
							prev_r_q <= '0;
							prev_b_q <= '0;
							head_q <= '0;
							x_q <= '0;
							y_q <= '0;
						end else begin
							dl_q <= twodo_pkg::sat_delta(33'(signed'(s_tdata[31:0]))
								- 33'(signed'(prev_l_q)));
							dr_q <= twodo_pkg::sat_delta(33'(signed'(s_tdata[63:32]))
								- 33'(signed'(prev_r_q)));
							db_q <= twodo_pkg::sat_delta(33'(signed'(s_tdata[95:64]))
								- 33'(signed'(prev_b_q)));
							prev_l_q <= s_tdata[31:0];
							prev_r_q <= s_tdata[63:32];
							prev_b_q <= s_tdata[95:64];
						end
						state_q <= s_tuser[0] ? ST_DONE : ST_PREP;
					end
				end
				ST_PREP: begin
					e_q <= e_now;
					w_q <= {1'b0, left_ofs_q} + {1'b0, right_ofs_q};
					dba_q <= '0;
					hba_q <= '0;
					md_req_q <= '{start: 1'b1, div: 1'b0,
						a: AW'(twodo_pkg::mag(TW'(e_now))), b: BW'(diam_q)};
					state_q <= ST_N_W;
				end
				ST_N_W: begin
					if (md_done) begin
						if (e_q != '0 && diam_q != '0 && w_q != '0) begin
							// heading step: |e|*D*2^32 / (720*w)
							md_req_q <= '{start: 1'b1, div: 1'b1,
								a: {4'b0000, md_res[47:0], 32'h0},
								b: BW'(BW'(w_q) * BW'(twodo_pkg::DEG_SCALE))};
							state_q <= ST_Q_W;
						end else begin
							md_req_q <= '{start: 1'b1, div: 1'b0,
								a: AW'(twodo_pkg::mag(TW'(db_q))), b: BW'(diam_q)};
							state_q <= ST_AB_W;
						end
					end
				end
				ST_Q_W: begin
					if (md_done) begin
						if (md_res[79:0] != '0) begin
							dba_q <= e_q[24] ? 32'h0 - md_res[31:0] : md_res[31:0];
							hba_q <= e_q[24] ? 32'h0 - half_mag : half_mag;
							md_req_q <= '{start: 1'b1, div: 1'b0,
								a: AW'(twodo_pkg::mag(TW'(db_q))), b: BW'(w_q)};
							state_q <= ST_PB_W;
						end else begin
							md_req_q <= '{start: 1'b1, div: 1'b0,
								a: AW'(twodo_pkg::mag(TW'(db_q))), b: BW'(diam_q)};
							state_q <= ST_AB_W;
						end
					end
				end
				ST_PB_W: begin
					if (md_done) begin
						md_req_q <= '{start: 1'b1, div: 1'b1, a: {35'h0, md_res[48:0]},
							b: BW'(twodo_pkg::mag(TW'(e_q)))};
						state_q <= ST_QB_W;
					end
				end
				ST_QB_W: begin
					if (md_done) begin
						lx_q <= twodo_pkg::with_sign(quot, db_q[23] ^ e_q[24])
							+ TW'(back_ofs_q);
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(TW'(dr_q))), b: BW'(w_q)};
						state_q <= ST_PR_W;
					end
				end
				ST_PR_W: begin
					if (md_done) begin
						md_req_q <= '{start: 1'b1, div: 1'b1, a: {35'h0, md_res[48:0]},
							b: BW'(twodo_pkg::mag(TW'(e_q)))};
						state_q <= ST_QR_W;
					end
				end
				ST_QR_W: begin
					if (md_done) begin
						ly_q <= twodo_pkg::with_sign(quot, dr_q[23] ^ e_q[24])
							+ TW'(right_ofs_q);
						cd_req_q <= '{start: 1'b1, angle: hba_q};
						state_q <= ST_CH_W;
					end
				end
				ST_CH_W: begin
					if (cd_done) begin
						sh_q <= cd_sin;
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(lx_q)),
							b: BW'(twodo_pkg::mag(TW'(cd_sin)))};
						state_q <= ST_SX_W;
					end
				end
				ST_SX_W: begin
					if (md_done) begin
						lx_q <= twodo_pkg::with_sign(prod30, lx_q[TW-1] ^ sh_q[CDW-1]) <<< 1;
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(ly_q)),
							b: BW'(twodo_pkg::mag(TW'(sh_q)))};
						state_q <= ST_SY_W;
					end
				end
				ST_SY_W: begin
					if (md_done) begin
						ly_q <= twodo_pkg::with_sign(prod30, ly_q[TW-1] ^ sh_q[CDW-1]) <<< 1;
						cd_req_q <= '{start: 1'b1, angle: head_q + hba_q};
						state_q <= ST_CM_W;
					end
				end
				ST_AB_W: begin
					if (md_done) begin
						md_req_q <= '{start: 1'b1, div: 1'b0, a: {36'h0, md_res[47:0]},
							b: BW'(twodo_pkg::ARC_K)};
						state_q <= ST_AB2_W;
					end
				end
				ST_AB2_W: begin
					if (md_done) begin
						lx_q <= twodo_pkg::with_sign(prod32, db_q[23]);
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(TW'(dr_q))), b: BW'(diam_q)};
						state_q <= ST_AR_W;
					end
				end
				ST_AR_W: begin
					if (md_done) begin
						md_req_q <= '{start: 1'b1, div: 1'b0, a: {36'h0, md_res[47:0]},
							b: BW'(twodo_pkg::ARC_K)};
						state_q <= ST_AR2_W;
					end
				end
				ST_AR2_W: begin
					if (md_done) begin
						ly_q <= twodo_pkg::with_sign(prod32, dr_q[23]);
						cd_req_q <= '{start: 1'b1, angle: head_q + hba_q};
						state_q <= ST_CM_W;
					end
				end
				ST_CM_W: begin
					if (cd_done) begin
						c_q <= cd_cos;
						s_q <= cd_sin;
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(lx_q)),
							b: BW'(twodo_pkg::mag(TW'(cd_cos)))};
						state_q <= ST_T1_W;
					end
				end
				ST_T1_W: begin
					if (md_done) begin
						u_q <= t_now;
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(ly_q)),
							b: BW'(twodo_pkg::mag(TW'(s_q)))};
						state_q <= ST_T2_W;
					end
				end
				ST_T2_W: begin
					if (md_done) begin
						sx_q <= u_q + t_now;
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(ly_q)),
							b: BW'(twodo_pkg::mag(TW'(c_q)))};
						state_q <= ST_T3_W;
					end
				end
				ST_T3_W: begin
					if (md_done) begin
						u_q <= t_now;
						md_req_q <= '{start: 1'b1, div: 1'b0,
							a: AW'(twodo_pkg::mag(lx_q)),
							b: BW'(twodo_pkg::mag(TW'(s_q)))};
						state_q <= ST_T4_W;
					end
				end
				ST_T4_W: begin
					if (md_done) begin
						x_q <= twodo_pkg::sat32(TW'(signed'(x_q)) + sx_q);
						y_q <= twodo_pkg::sat32(TW'(signed'(y_q)) + (u_q - t_now));
						head_q <= head_q + dba_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {head_q, y_q, x_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTH
	a_md_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q != ST_IDLE && state_q != ST_DONE && state_q != ST_PREP))
		else $error("multiply/divide finished outside a wait state");

	a_cd_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cd_done |-> (state_q == ST_CH_W || state_q == ST_CM_W))
		else $error("rotation finished outside a rotation wait state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result presented without finishing an item");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(md_req_q.start |-> !cd_req_q.start))
		else $error("both shared units started together");
`endif

endmodule
